// ===== rtl/core/fnfp_pkg.sv =====
// fnfp_pkg: shared types and constants for the face normal pipeline
// no dependencies
`default_nettype none
package fnfp_pkg;

	localparam int unsigned FxWidth    = 32;
	localparam int unsigned RootWidth  = 24;
	localparam int unsigned RadWidth   = 48;
	localparam int unsigned RemWidth   = 28;
	localparam int unsigned DivSteps   = 48;
	localparam int unsigned SqrtSteps  = 24;

	typedef struct packed {
		logic signed [FxWidth-1:0] x;
		logic signed [FxWidth-1:0] y;
		logic signed [FxWidth-1:0] z;
	} fnfp_vec_t;

	typedef struct packed {
		logic degenerate;
		logic overflow;
	} fnfp_flag_t;

	function automatic logic signed [FxWidth-1:0] fx_mul(
		input logic signed [FxWidth-1:0] a,
		input logic signed [FxWidth-1:0] b
	);
		logic signed [2*FxWidth-1:0] p;
		p = (2*FxWidth)'(a) * (2*FxWidth)'(b);
		return p[FxWidth+15:16];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fnfp_cross.sv =====
// fnfp_cross: edge vectors, cross product partial products, cross product
// depends on fnfp_pkg
`default_nettype none
module fnfp_cross import fnfp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_v,
	input  wire fnfp_vec_t a,
	input  wire fnfp_vec_t b,
	input  wire fnfp_vec_t c,
	output logic           out_v,
	output fnfp_vec_t      n
);
	logic      v_s1, v_s2, v_s3;
	fnfp_vec_t e1_s1, e2_s1;
	logic signed [FxWidth-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	fnfp_vec_t n_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1.x <= b.x - a.x;
			e1_s1.y <= b.y - a.y;
			e1_s1.z <= b.z - a.z;
			e2_s1.x <= c.x - a.x;
			e2_s1.y <= c.y - a.y;
			e2_s1.z <= c.z - a.z;
			p0_s2 <= fx_mul(e1_s1.y, e2_s1.z);
			p1_s2 <= fx_mul(e1_s1.z, e2_s1.y);
			p2_s2 <= fx_mul(e1_s1.z, e2_s1.x);
			p3_s2 <= fx_mul(e1_s1.x, e2_s1.z);
			p4_s2 <= fx_mul(e1_s1.x, e2_s1.y);
			p5_s2 <= fx_mul(e1_s1.y, e2_s1.x);
			n_s3.x <= p0_s2 - p1_s2;
			n_s3.y <= p2_s2 - p3_s2;
			n_s3.z <= p4_s2 - p5_s2;
		end
	end

	assign out_v = v_s3;
	assign n     = n_s3;
endmodule
`default_nettype wire

// ===== rtl/core/fnfp_norm.sv =====
// fnfp_norm: squared length of the cross product and its status flags
// depends on fnfp_pkg
`default_nettype none
module fnfp_norm import fnfp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_v,
	input  wire fnfp_vec_t n,
	output logic           out_v,
	output fnfp_vec_t      n_out,
	output logic [FxWidth-1:0] sum,
	output fnfp_flag_t     flags
);
	logic      v_s1, v_s2;
	fnfp_vec_t n_s1, n_s2;
	logic signed [FxWidth-1:0] qx_s1, qy_s1, qz_s1;
	logic [FxWidth-1:0] sum_s2;
	logic [FxWidth-1:0] total;

	assign total = qx_s1 + qy_s1 + qz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1   <= n;
			qx_s1  <= fx_mul(n.x, n.x);
			qy_s1  <= fx_mul(n.y, n.y);
			qz_s1  <= fx_mul(n.z, n.z);
			n_s2   <= n_s1;
			sum_s2 <= total;
		end
	end

	assign out_v            = v_s2;
	assign n_out            = n_s2;
	assign sum              = sum_s2;
	assign flags.overflow   = sum_s2[FxWidth-1];
	assign flags.degenerate = (sum_s2 == '0);
endmodule
`default_nettype wire

// ===== rtl/core/fnfp_sqrt.sv =====
// fnfp_sqrt: bit-per-stage square root of the squared length, 8.16 result
// depends on fnfp_pkg
`default_nettype none
module fnfp_sqrt import fnfp_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_v,
	input  wire fnfp_vec_t      n,
	input  wire logic [FxWidth-1:0] sum,
	input  wire fnfp_flag_t     flags,
	output logic                out_v,
	output fnfp_vec_t           n_out,
	output fnfp_flag_t          flags_out,
	output logic [RootWidth-1:0] len
);
	logic                 v_s    [0:SqrtSteps];
	fnfp_vec_t            n_s    [0:SqrtSteps];
	fnfp_flag_t           f_s    [0:SqrtSteps];
	logic [RadWidth-1:0]  rad_s  [0:SqrtSteps];
	logic [RemWidth-1:0]  rem_s  [0:SqrtSteps];
	logic [RootWidth-1:0] root_s [0:SqrtSteps];

	assign v_s[0]    = in_v;
	assign n_s[0]    = n;
	assign f_s[0]    = flags;
	assign rad_s[0]  = {1'b0, sum[FxWidth-2:0], 16'b0};
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
		logic [RemWidth-1:0] r2, t;
		logic                ge;
		assign r2 = {rem_s[k][RemWidth-3:0], rad_s[k][RadWidth-1:RadWidth-2]};
		assign t  = {2'b00, root_s[k], 2'b01};
		assign ge = (r2 >= t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1]    <= n_s[k];
				f_s[k+1]    <= f_s[k];
				rad_s[k+1]  <= {rad_s[k][RadWidth-3:0], 2'b00};
				rem_s[k+1]  <= ge ? (r2 - t) : r2;
				root_s[k+1] <= {root_s[k][RootWidth-2:0], ge};
			end
		end
	end

	assign out_v     = v_s[SqrtSteps];
	assign n_out     = n_s[SqrtSteps];
	assign flags_out = f_s[SqrtSteps];
	assign len       = root_s[SqrtSteps];
endmodule
`default_nettype wire

// ===== rtl/core/fnfp_div.sv =====
// fnfp_div: three-lane restoring divider, one quotient bit per stage, plus sign fixup
// depends on fnfp_pkg
`default_nettype none
module fnfp_div import fnfp_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_v,
	input  wire fnfp_vec_t       n,
	input  wire fnfp_flag_t      flags,
	input  wire logic [RootWidth-1:0] len,
	output logic                 out_v,
	output fnfp_vec_t            q,
	output fnfp_flag_t           flags_out
);
	logic                 v_s   [0:DivSteps];
	fnfp_flag_t           f_s   [0:DivSteps];
	logic [RootWidth-1:0] len_s [0:DivSteps];
	logic [2:0]           neg_s [0:DivSteps];
	logic [RadWidth-1:0]  dd_s  [0:DivSteps][0:2];
	logic [RootWidth-1:0] rem_s [0:DivSteps][0:2];
	logic [FxWidth-1:0]   q_s   [0:DivSteps][0:2];
	logic                 v_fin;
	fnfp_vec_t            q_fin;
	fnfp_flag_t           f_fin;
	logic [FxWidth-1:0]   nin   [0:2];
	logic                 kill;

	assign nin[0] = n.x;
	assign nin[1] = n.y;
	assign nin[2] = n.z;

	assign v_s[0]   = in_v;
	assign f_s[0]   = flags;
	assign len_s[0] = len;

	for (genvar l = 0; l < 3; l++) begin : g_lane_in
		logic [FxWidth-1:0] mag;
		assign mag          = nin[l][FxWidth-1] ? (~nin[l] + 1'b1) : nin[l];
		assign neg_s[0][l]  = nin[l][FxWidth-1];
		assign dd_s[0][l]   = {mag, 16'b0};
		assign rem_s[0][l]  = '0;
		assign q_s[0][l]    = '0;
	end

	for (genvar k = 0; k < DivSteps; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				f_s[k+1]   <= f_s[k];
				len_s[k+1] <= len_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [RootWidth:0] r2, d;
			logic               ge;
			logic [RootWidth:0] diff;
			assign r2   = {rem_s[k][l], dd_s[k][l][RadWidth-1]};
			assign d    = {1'b0, len_s[k]};
			assign ge   = (r2 >= d);
			assign diff = r2 - d;

			always_ff @(posedge clk) begin
				if (en) begin
					dd_s[k+1][l]  <= {dd_s[k][l][RadWidth-2:0], 1'b0};
					rem_s[k+1][l] <= ge ? diff[RootWidth-1:0] : r2[RootWidth-1:0];
					q_s[k+1][l]   <= {q_s[k][l][FxWidth-2:0], ge};
				end
			end
		end
	end

	assign kill = f_s[DivSteps].degenerate | f_s[DivSteps].overflow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_fin <= 1'b0;
		end else if (en) begin
			v_fin <= v_s[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_fin   <= f_s[DivSteps];
			q_fin.x <= kill ? '0 : (neg_s[DivSteps][0] ? (~q_s[DivSteps][0] + 1'b1)
			                                           : q_s[DivSteps][0]);
			q_fin.y <= kill ? '0 : (neg_s[DivSteps][1] ? (~q_s[DivSteps][1] + 1'b1)
			                                           : q_s[DivSteps][1]);
			q_fin.z <= kill ? '0 : (neg_s[DivSteps][2] ? (~q_s[DivSteps][2] + 1'b1)
			                                           : q_s[DivSteps][2]);
		end
	end

	assign out_v     = v_fin;
	assign q         = q_fin;
	assign flags_out = f_fin;
endmodule
`default_nettype wire

// ===== rtl/core/face_normal_fixed_point.sv =====
// face_normal_fixed_point: unit normal of a triangle in signed 16.16 fixed point
// depends on fnfp_pkg, fnfp_cross, fnfp_norm, fnfp_sqrt, fnfp_div
//
// input channel: in_valid / in_stall with the nine vertex coordinates of one triangle
// output channel: out_valid / out_stall with normal_x/y/z, degenerate and overflow
// a word is taken on an edge where valid is high and stall is low
// from input acceptance to the result word on the outputs a word passes through
// 3 cross product stages, 2 length stages, 24 square root stages (one root
// bit each), 48 divider stages (one quotient bit each) and one sign fixup stage
// throughput is one triangle per cycle while in_stall is low; the three
// components share the divider stages side by side
// a skid register behind the last stage catches a word while out_stall is high;
// the pipeline then holds and in_stall rises until the skid word is taken
// degenerate: zero length, normal forced to zero
// overflow: wrapped squared length negative, normal forced to zero
// reset empties every stage and the skid register; no word is in flight after it
`default_nettype none
module face_normal_fixed_point import fnfp_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [FxWidth-1:0] first_x,
	input  wire logic signed [FxWidth-1:0] first_y,
	input  wire logic signed [FxWidth-1:0] first_z,
	input  wire logic signed [FxWidth-1:0] second_x,
	input  wire logic signed [FxWidth-1:0] second_y,
	input  wire logic signed [FxWidth-1:0] second_z,
	input  wire logic signed [FxWidth-1:0] third_x,
	input  wire logic signed [FxWidth-1:0] third_y,
	input  wire logic signed [FxWidth-1:0] third_z,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [FxWidth-1:0]      normal_x,
	output logic signed [FxWidth-1:0]      normal_y,
	output logic signed [FxWidth-1:0]      normal_z,
	output logic                           degenerate,
	output logic                           overflow
);
	logic       en;
	fnfp_vec_t  va, vb, vc;
	logic       cr_v, nm_v, sq_v, dv_v;
	fnfp_vec_t  cr_n, nm_n, sq_n, dv_q;
	logic [FxWidth-1:0] nm_sum;
	fnfp_flag_t nm_f, sq_f, dv_f;
	logic [RootWidth-1:0] sq_len;
	logic       skid_q;
	fnfp_vec_t  skid_n_q;
	fnfp_flag_t skid_f_q;

	assign en = !skid_q;
	assign in_stall = skid_q;

	assign va = '{x: first_x, y: first_y, z: first_z};
	assign vb = '{x: second_x, y: second_y, z: second_z};
	assign vc = '{x: third_x, y: third_y, z: third_z};

	fnfp_cross u_cross (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(in_valid),
		.a(va), .b(vb), .c(vc), .out_v(cr_v), .n(cr_n)
	);

	fnfp_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(cr_v), .n(cr_n),
		.out_v(nm_v), .n_out(nm_n), .sum(nm_sum), .flags(nm_f)
	);

	fnfp_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(nm_v), .n(nm_n),
		.sum(nm_sum), .flags(nm_f), .out_v(sq_v), .n_out(sq_n),
		.flags_out(sq_f), .len(sq_len)
	);

	fnfp_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(sq_v), .n(sq_n),
		.flags(sq_f), .len(sq_len), .out_v(dv_v), .q(dv_q), .flags_out(dv_f)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			skid_q <= out_stall;
		end else begin
			skid_q <= dv_v && out_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			skid_n_q <= dv_q;
			skid_f_q <= dv_f;
		end
	end

	assign out_valid  = skid_q | dv_v;
	assign normal_x   = skid_q ? skid_n_q.x : dv_q.x;
	assign normal_y   = skid_q ? skid_n_q.y : dv_q.y;
	assign normal_z   = skid_q ? skid_n_q.z : dv_q.z;
	assign degenerate = skid_q ? skid_f_q.degenerate : dv_f.degenerate;
	assign overflow   = skid_q ? skid_f_q.overflow : dv_f.overflow;

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && degenerate && overflow))
		else $error("degenerate and overflow both set");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (degenerate || overflow) |->
		normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("flagged word has nonzero normal");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q && out_stall |=> skid_q && $stable(skid_n_q))
		else $error("skid word lost while stalled");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_q && dv_v && out_stall |=> skid_q && skid_n_q == $past(dv_q))
		else $error("stalled result not captured");
endmodule
`default_nettype wire
